[rtl/imrc_pkg.sv]
// Shared widths, result codes and helpers for the IOVA magazine range cache.
// No dependencies.
package imrc_pkg;

  localparam int SIZE_W = 20;
  localparam int OUT_FRAME_W = 36;
  localparam int CLS_W = 5;

  localparam logic [2:0] KIND_HIT = 3'd0;
  localparam logic [2:0] KIND_MISS = 3'd1;
  localparam logic [2:0] KIND_CACHED = 3'd2;
  localparam logic [2:0] KIND_REJECTED = 3'd3;
  localparam logic [2:0] KIND_EVICTED = 3'd4;

  // ceil(log2(n)), 0 for n <= 1
  function automatic logic [CLS_W-1:0] ceil_log2(input logic [SIZE_W-1:0] n);
    logic [CLS_W-1:0] r;
    r = CLS_W'(SIZE_W);
    for (int i = SIZE_W; i >= 0; i--) begin
      if ((SIZE_W+1)'(1) << i >= (SIZE_W+1)'(n)) begin
        r = CLS_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/imrc_mag_store.sv]
// Magazine slot memory with registered read and the shared bound comparator.
// Uses imrc_pkg for the output frame width.
module imrc_mag_store #(
  parameter int DW = 36,
  parameter int DEPTH = 6528
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]        wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  input  logic [DW-1:0]        bound_i,
  output logic [DW-1:0]        rdata_o,
  output logic [imrc_pkg::OUT_FRAME_W-1:0] rframe_o,
  output logic                 fit_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign rframe_o = imrc_pkg::OUT_FRAME_W'(rdata_q);
  assign fit_o = (rdata_q <= bound_i);

endmodule

[rtl/iova_magazine_range_cache.sv]
// Top level of the IOVA magazine range cache; uses imrc_pkg and imrc_mag_store.
// A get scans its magazine slot by slot from the top; a free that evicts a magazine
// sends one evicted beat per cycle from the slot memory read port.
// One item at a time: busy is high until the last beat goes out; results cannot stall.
// Reset (async, active low) empties all magazines at once; no clearing pass.
module iova_magazine_range_cache #(
  parameter int SIZE_CLASSES = 6,
  parameter int MAG_ENTRIES = 32,
  parameter int DEPOT_DEPTH = 32,
  parameter int FRAME_BITS = 36
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [19:0] range_pages_i,
  input  logic [35:0] frame_i,
  input  logic [35:0] limit_frame_i,
  output logic        res_strobe_o,
  output logic [2:0]  kind_o,
  output logic [35:0] result_frame_o,
  output logic        last_o
);

  localparam int FW = (FRAME_BITS < 36) ? FRAME_BITS : 36;
  localparam int MPC = DEPOT_DEPTH + 2;
  localparam int TM = SIZE_CLASSES * MPC;
  localparam int MW = (TM > 1) ? $clog2(TM) : 1;
  localparam int IDW = $clog2(MPC);
  localparam int FLW = $clog2(MAG_ENTRIES + 1);
  localparam int ENW = $clog2(MAG_ENTRIES);
  localparam int CNTW = $clog2(DEPOT_DEPTH + 1);
  localparam int DN = SIZE_CLASSES * DEPOT_DEPTH;
  localparam int DAW = (DN > 1) ? $clog2(DN) : 1;
  localparam int SLOTS = TM * MAG_ENTRIES;
  localparam int SAW = $clog2(SLOTS);
  localparam int SCW = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int CW = imrc_pkg::CLS_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEC, ST_F_LD, ST_F_PV, ST_F_SPR, ST_EVICT, ST_PUSH,
    ST_G_LD, ST_G_PV, ST_G_DEP, ST_G_FILL, ST_SCAN
  } state_e;

  state_e state_q, state_d;
  logic func_q, func_d;
  logic [19:0] size_q, size_d;
  logic [FW-1:0] frame_q, frame_d, limit_q, limit_d, bound_q, bound_d, top_q, top_d;
  logic [CW-1:0] cls_q, cls_d;
  logic [IDW-1:0] ld_q [SIZE_CLASSES];
  logic [IDW-1:0] ld_d [SIZE_CLASSES];
  logic [IDW-1:0] pv_q [SIZE_CLASSES];
  logic [IDW-1:0] pv_d [SIZE_CLASSES];
  logic [CNTW-1:0] dc_q [SIZE_CLASSES];
  logic [CNTW-1:0] dc_d [SIZE_CLASSES];
  logic [CNTW-1:0] sc_q [SIZE_CLASSES];
  logic [CNTW-1:0] sc_d [SIZE_CLASSES];
  logic [MW-1:0] m_q, m_d;
  logic [FLW-1:0] fill_q, fill_d, cnt_q, cnt_d;
  logic pend_q, pend_d;
  logic [ENW-1:0] pidx_q, pidx_d;
  logic strobe_q, strobe_d, last_q, last_d;
  logic [2:0] kind_q, kind_d;
  logic [35:0] rframe_q, rframe_d;

  // fill counts, with valid bits for reset
  logic [FLW-1:0] fill_mem [TM];
  logic fill_vld_q [TM];
  logic fill_re, fill_we;
  logic [MW-1:0] fill_ra, fill_wa;
  logic [FLW-1:0] fill_wd, fill_rd_q;

  // depot stacks
  logic [IDW-1:0] dep_mem [DN];
  logic dep_re, dep_we;
  logic [DAW-1:0] dep_ra, dep_wa;
  logic [IDW-1:0] dep_wd, dep_rd_q;

  // spare stacks; unwritten entry k reads as id k+2
  logic [IDW-1:0] spr_mem [DN];
  logic spr_vld_q [DN];
  logic spr_re, spr_we;
  logic [DAW-1:0] spr_ra, spr_wa;
  logic [CNTW-1:0] spr_rk;
  logic [IDW-1:0] spr_wd, spr_rd_q;

  logic slot_re, slot_we, fit;
  logic [SAW-1:0] slot_ra, slot_wa;
  logic [FW-1:0] slot_wd, slot_rd;
  logic [35:0] slot_rframe;

  logic [CW-1:0] dec_cls;
  logic [FW:0] dec_top, dec_eff;
  logic [SCW-1:0] ci, dci;
  logic [IDW-1:0] ld, pv;
  logic [CNTW-1:0] dc, sc;
  logic [FW-1:0] topv;

  function automatic logic [MW-1:0] mag_of(input logic [SCW-1:0] c, input logic [IDW-1:0] id);
    return MW'(MW'(c) * MW'(MPC)) + MW'(id);
  endfunction

  function automatic logic [DAW-1:0] stk_of(input logic [SCW-1:0] c, input logic [CNTW-1:0] k);
    return DAW'(DAW'(c) * DAW'(DEPOT_DEPTH)) + DAW'(k);
  endfunction

  function automatic logic [SAW-1:0] slot_of(input logic [MW-1:0] m, input logic [FLW-1:0] i);
    return SAW'(SAW'(m) * SAW'(MAG_ENTRIES)) + SAW'(i);
  endfunction

  imrc_mag_store #(.DW(FW), .DEPTH(SLOTS)) u_store (
    .clk_i    (clk_i),
    .we_i     (slot_we),
    .waddr_i  (slot_wa),
    .wdata_i  (slot_wd),
    .re_i     (slot_re),
    .raddr_i  (slot_ra),
    .bound_i  (bound_q),
    .rdata_o  (slot_rd),
    .rframe_o (slot_rframe),
    .fit_o    (fit)
  );

  assign ci = cls_q[SCW-1:0];
  assign ld = ld_q[ci];
  assign pv = pv_q[ci];
  assign dc = dc_q[ci];
  assign sc = sc_q[ci];
  assign dec_cls = imrc_pkg::ceil_log2(size_q);
  assign dci = dec_cls[SCW-1:0];
  assign dec_top = {1'b0, limit_q} + (FW+1)'(1);
  assign dec_eff = (FW+1)'(1) << dec_cls;
  assign topv = (FLW'(pidx_q) == fill_q - FLW'(1)) ? slot_rd : top_q;

  always_comb begin
    state_d = state_q;
    func_d = func_q;
    size_d = size_q;
    frame_d = frame_q;
    limit_d = limit_q;
    bound_d = bound_q;
    top_d = top_q;
    cls_d = cls_q;
    ld_d = ld_q;
    pv_d = pv_q;
    dc_d = dc_q;
    sc_d = sc_q;
    m_d = m_q;
    fill_d = fill_q;
    cnt_d = cnt_q;
    pend_d = pend_q;
    pidx_d = pidx_q;
    strobe_d = 1'b0;
    last_d = 1'b0;
    kind_d = kind_q;
    rframe_d = rframe_q;
    fill_re = 1'b0;
    fill_ra = mag_of(ci, ld);
    fill_we = 1'b0;
    fill_wa = m_q;
    fill_wd = fill_q + FLW'(1);
    dep_re = 1'b0;
    dep_ra = stk_of(ci, dc - CNTW'(1));
    dep_we = 1'b0;
    dep_wa = stk_of(ci, dc);
    dep_wd = ld;
    spr_re = 1'b0;
    spr_rk = sc - CNTW'(1);
    spr_ra = stk_of(ci, sc - CNTW'(1));
    spr_we = 1'b0;
    spr_wa = stk_of(ci, sc);
    spr_wd = ld;
    slot_re = 1'b0;
    slot_ra = slot_of(m_q, cnt_q);
    slot_we = 1'b0;
    slot_wa = slot_of(m_q, fill_q);
    slot_wd = frame_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          func_d = func_i;
          size_d = range_pages_i;
          frame_d = FW'(frame_i);
          limit_d = FW'(limit_frame_i);
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        cls_d = dec_cls;
        fill_ra = mag_of(dci, ld_q[dci]);
        if (dec_cls >= CW'(SIZE_CLASSES)) begin
          strobe_d = 1'b1;
          last_d = 1'b1;
          kind_d = func_q ? imrc_pkg::KIND_REJECTED : imrc_pkg::KIND_MISS;
          rframe_d = '0;
          state_d = ST_IDLE;
        end else if (func_q) begin
          fill_re = 1'b1;
          state_d = ST_F_LD;
        end else if (dec_eff > dec_top) begin
          strobe_d = 1'b1;
          last_d = 1'b1;
          kind_d = imrc_pkg::KIND_MISS;
          rframe_d = '0;
          state_d = ST_IDLE;
        end else begin
          bound_d = FW'(dec_top - dec_eff);
          fill_re = 1'b1;
          state_d = ST_G_LD;
        end
      end
      ST_F_LD: begin
        if (fill_rd_q < FLW'(MAG_ENTRIES)) begin
          m_d = mag_of(ci, ld);
          fill_d = fill_rd_q;
          state_d = ST_PUSH;
        end else begin
          fill_re = 1'b1;
          fill_ra = mag_of(ci, pv);
          state_d = ST_F_PV;
        end
      end
      ST_F_PV: begin
        if (fill_rd_q < FLW'(MAG_ENTRIES)) begin
          ld_d[ci] = pv;
          pv_d[ci] = ld;
          m_d = mag_of(ci, pv);
          fill_d = fill_rd_q;
          state_d = ST_PUSH;
        end else if (dc < CNTW'(DEPOT_DEPTH) && sc != '0) begin
          spr_re = 1'b1;
          state_d = ST_F_SPR;
        end else begin
          m_d = mag_of(ci, ld);
          cnt_d = '0;
          fill_d = FLW'(MAG_ENTRIES);
          pend_d = 1'b0;
          state_d = ST_EVICT;
        end
      end
      ST_F_SPR: begin
        dep_we = 1'b1;
        dc_d[ci] = dc + CNTW'(1);
        sc_d[ci] = sc - CNTW'(1);
        ld_d[ci] = spr_rd_q;
        m_d = mag_of(ci, spr_rd_q);
        fill_d = '0;
        state_d = ST_PUSH;
      end
      ST_EVICT: begin
        // read slot i while beat i-1 goes out
        if (cnt_q < fill_q) begin
          slot_re = 1'b1;
          cnt_d = cnt_q + FLW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          strobe_d = 1'b1;
          kind_d = imrc_pkg::KIND_EVICTED;
          rframe_d = slot_rframe;
        end else if (cnt_q == fill_q) begin
          fill_d = '0;
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        slot_we = 1'b1;
        fill_we = 1'b1;
        strobe_d = 1'b1;
        last_d = 1'b1;
        kind_d = imrc_pkg::KIND_CACHED;
        rframe_d = '0;
        state_d = ST_IDLE;
      end
      ST_G_LD: begin
        if (fill_rd_q != '0) begin
          m_d = mag_of(ci, ld);
          fill_d = fill_rd_q;
          cnt_d = fill_rd_q;
          pend_d = 1'b0;
          state_d = ST_SCAN;
        end else begin
          fill_re = 1'b1;
          fill_ra = mag_of(ci, pv);
          state_d = ST_G_PV;
        end
      end
      ST_G_PV: begin
        if (fill_rd_q != '0) begin
          ld_d[ci] = pv;
          pv_d[ci] = ld;
          m_d = mag_of(ci, pv);
          fill_d = fill_rd_q;
          cnt_d = fill_rd_q;
          pend_d = 1'b0;
          state_d = ST_SCAN;
        end else if (dc != '0 && sc < CNTW'(DEPOT_DEPTH)) begin
          spr_we = 1'b1;
          sc_d[ci] = sc + CNTW'(1);
          dc_d[ci] = dc - CNTW'(1);
          dep_re = 1'b1;
          state_d = ST_G_DEP;
        end else begin
          strobe_d = 1'b1;
          last_d = 1'b1;
          kind_d = imrc_pkg::KIND_MISS;
          rframe_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_G_DEP: begin
        ld_d[ci] = dep_rd_q;
        m_d = mag_of(ci, dep_rd_q);
        fill_re = 1'b1;
        fill_ra = mag_of(ci, dep_rd_q);
        state_d = ST_G_FILL;
      end
      ST_G_FILL: begin
        fill_d = fill_rd_q;
        cnt_d = fill_rd_q;
        pend_d = 1'b0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // top-down scan; the first slot read is the top, kept for the swap-pop
        if (cnt_q != '0) begin
          slot_re = 1'b1;
          slot_ra = slot_of(m_q, cnt_q - FLW'(1));
          pidx_d = ENW'(cnt_q - FLW'(1));
          cnt_d = cnt_q - FLW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          top_d = topv;
          if (fit) begin
            slot_we = 1'b1;
            slot_wa = slot_of(m_q, FLW'(pidx_q));
            slot_wd = topv;
            fill_we = 1'b1;
            fill_wd = fill_q - FLW'(1);
            strobe_d = 1'b1;
            last_d = 1'b1;
            kind_d = imrc_pkg::KIND_HIT;
            rframe_d = slot_rframe;
            state_d = ST_IDLE;
          end
        end else if (cnt_q == '0) begin
          strobe_d = 1'b1;
          last_d = 1'b1;
          kind_d = imrc_pkg::KIND_MISS;
          rframe_d = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q <= 1'b0;
      strobe_q <= 1'b0;
      last_q <= 1'b0;
      kind_q <= imrc_pkg::KIND_MISS;
      rframe_q <= '0;
      for (int c = 0; c < SIZE_CLASSES; c++) begin
        ld_q[c] <= '0;
        pv_q[c] <= IDW'(1);
        dc_q[c] <= '0;
        sc_q[c] <= CNTW'(DEPOT_DEPTH);
      end
    end else begin
      state_q <= state_d;
      pend_q <= pend_d;
      strobe_q <= strobe_d;
      last_q <= last_d;
      kind_q <= kind_d;
      rframe_q <= rframe_d;
      ld_q <= ld_d;
      pv_q <= pv_d;
      dc_q <= dc_d;
      sc_q <= sc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    size_q <= size_d;
    frame_q <= frame_d;
    limit_q <= limit_d;
    bound_q <= bound_d;
    top_q <= top_d;
    cls_q <= cls_d;
    m_q <= m_d;
    fill_q <= fill_d;
    cnt_q <= cnt_d;
    pidx_q <= pidx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TM; i++) begin
        fill_vld_q[i] <= 1'b0;
      end
      for (int i = 0; i < DN; i++) begin
        spr_vld_q[i] <= 1'b0;
      end
    end else begin
      if (fill_we) begin
        fill_vld_q[fill_wa] <= 1'b1;
      end
      if (spr_we) begin
        spr_vld_q[spr_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    if (fill_re) begin
      fill_rd_q <= fill_vld_q[fill_ra] ? fill_mem[fill_ra] : '0;
    end
    if (dep_we) begin
      dep_mem[dep_wa] <= dep_wd;
    end
    if (dep_re) begin
      dep_rd_q <= dep_mem[dep_ra];
    end
    if (spr_we) begin
      spr_mem[spr_wa] <= spr_wd;
    end
    if (spr_re) begin
      spr_rd_q <= spr_vld_q[spr_ra] ? spr_mem[spr_ra] : IDW'(spr_rk) + IDW'(2);
    end
  end

  assign busy = (state_q != ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign kind_o = kind_q;
  assign result_frame_o = rframe_q;
  assign last_o = last_q;

endmodule
